// File: rtl/tmse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turing machine step engine package
// Shared types, codes and constants for the step engine, its controller and
// its storage.
// ----------------------------------------------------------------------------
package tmse_pkg;

  // Symbols and tape.
  localparam int unsigned SYMBOL_BITS = 8;
  localparam int unsigned SYM_COUNT   = 1 << SYMBOL_BITS;
  localparam int unsigned TAPE_CELLS  = 4096;
  localparam int unsigned TAPE_AW     = $clog2(TAPE_CELLS);

  localparam logic [SYMBOL_BITS-1:0] BLANK = SYMBOL_BITS'(95);
  localparam logic [SYMBOL_BITS-1:0] BANG  = SYMBOL_BITS'(33);

  localparam logic signed [TAPE_AW-1:0] HEAD_MAX = TAPE_AW'(TAPE_CELLS / 2 - 1);
  localparam logic signed [TAPE_AW-1:0] HEAD_MIN = TAPE_AW'(TAPE_CELLS / 2);

  localparam logic signed [8:0] NO_NEXT = -9'sd2;

  localparam logic [1:0] MOVE_NONE  = 2'd0;
  localparam logic [1:0] MOVE_RIGHT = 2'd1;

  // Stream widths.
  localparam int unsigned ITEM_W      = 46;
  localparam int unsigned TDATA_IN_W  = 48;
  localparam int unsigned TDATA_OUT_W = 40;

  typedef enum logic [2:0] {
    KIND_STEP  = 3'd0,
    KIND_LOAD  = 3'd1,
    KIND_ALLOW = 3'd2,
    KIND_CLEAR = 3'd3,
    KIND_CELL  = 3'd4
  } tmse_kind_e;

  typedef enum logic [2:0] {
    STATUS_APPLIED  = 3'd0,
    STATUS_NO_TRANS = 3'd1,
    STATUS_RANGE    = 3'd2,
    STATUS_REJECT   = 3'd3,
    STATUS_LIMIT    = 3'd4,
    STATUS_DONE     = 3'd5
  } tmse_status_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_TBL,
    ST_ALW,
    ST_CLR,
    ST_EXEC
  } tmse_fsm_e;

  // Request payload, last field in the lowest bits.
  typedef struct packed {
    logic signed [TAPE_AW-1:0]   cell_pos;
    logic [1:0]                  move;
    logic signed [8:0]           goto_state;
    logic [SYMBOL_BITS-1:0]      wsym;
    logic                        valid;
    logic [SYMBOL_BITS-1:0]      rsym;
    logic [5:0]                  sidx;
  } tmse_item_t;

  // Result payload, status in the lowest bits.
  typedef struct packed {
    logic [1:0]                  move;
    logic signed [8:0]           next;
    logic [SYMBOL_BITS-1:0]      sym;
    logic signed [TAPE_AW-1:0]   head;
    logic [5:0]                  state;
    logic [2:0]                  status;
  } tmse_result_t;

  // One transition table entry.
  typedef struct packed {
    logic                        valid;
    logic [SYMBOL_BITS-1:0]      sym;
    logic signed [8:0]           next;
    logic [1:0]                  move;
  } tmse_entry_t;

  // Memory port strobes from the controller.
  typedef struct packed {
    logic tape_re;
    logic tape_we;
    logic tbl_re;
    logic tbl_we;
    logic alw_re;
    logic alw_we;
  } tmse_mem_ctl_t;

  // Signed cell index to tape address: the midpoint of the tape is cell zero.
  function automatic logic [TAPE_AW-1:0] tape_addr(input logic signed [TAPE_AW-1:0] p);
    return {~p[TAPE_AW-1], p[TAPE_AW-2:0]};
  endfunction

endpackage

// File: rtl/tmse_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step engine storage
// Transition table, allowed-symbol set and tape, each a synchronous memory
// with one write port and one registered read port.
// ----------------------------------------------------------------------------
module tmse_mem #(
  parameter int unsigned MAX_STATES = 64
) (
  input  logic                                   clk_i,
  input  tmse_pkg::tmse_mem_ctl_t                mem_ctl_i,
  input  logic [tmse_pkg::TAPE_AW-1:0]           tape_raddr_i,
  input  logic [tmse_pkg::TAPE_AW-1:0]           tape_waddr_i,
  input  logic [tmse_pkg::SYMBOL_BITS-1:0]       tape_wdata_i,
  output logic [tmse_pkg::SYMBOL_BITS-1:0]       tape_rdata_o,
  input  logic [$clog2(MAX_STATES)+tmse_pkg::SYMBOL_BITS-1:0] tbl_raddr_i,
  input  logic [$clog2(MAX_STATES)+tmse_pkg::SYMBOL_BITS-1:0] tbl_waddr_i,
  input  tmse_pkg::tmse_entry_t                  tbl_wdata_i,
  output tmse_pkg::tmse_entry_t                  tbl_rdata_o,
  input  logic [tmse_pkg::SYMBOL_BITS-1:0]       alw_raddr_i,
  input  logic [tmse_pkg::SYMBOL_BITS-1:0]       alw_waddr_i,
  input  logic                                   alw_wdata_i,
  output logic                                   alw_rdata_o
);
  import tmse_pkg::*;

  localparam int unsigned TBL_DEPTH = MAX_STATES * SYM_COUNT;

  tmse_entry_t            tbl_mem  [TBL_DEPTH];
  logic [SYMBOL_BITS-1:0] tape_mem [TAPE_CELLS];
  logic                   alw_mem  [SYM_COUNT];

  tmse_entry_t            tbl_rdata_q;
  logic [SYMBOL_BITS-1:0] tape_rdata_q;
  logic                   alw_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.tbl_we) begin
      tbl_mem[tbl_waddr_i] <= tbl_wdata_i;
    end
    if (mem_ctl_i.tbl_re) begin
      tbl_rdata_q <= tbl_mem[tbl_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.tape_we) begin
      tape_mem[tape_waddr_i] <= tape_wdata_i;
    end
    if (mem_ctl_i.tape_re) begin
      tape_rdata_q <= tape_mem[tape_raddr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_ctl_i.alw_we) begin
      alw_mem[alw_waddr_i] <= alw_wdata_i;
    end
    if (mem_ctl_i.alw_re) begin
      alw_rdata_q <= alw_mem[alw_raddr_i];
    end
  end

  assign tbl_rdata_o  = tbl_rdata_q;
  assign tape_rdata_o = tape_rdata_q;
  assign alw_rdata_o  = alw_rdata_q;

endmodule

// File: rtl/tmse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step engine controller
// Sequences memory reads and write-back for each request, holds the machine
// state and head, runs the clearing sweeps and owns the result register.
// ----------------------------------------------------------------------------
module tmse_ctrl #(
  parameter int unsigned MAX_STATES = 64
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [6:0]                             num_states_i,
  input  logic                                   s_valid_i,
  output logic                                   s_ready_o,
  input  logic [2:0]                             s_kind_i,
  input  tmse_pkg::tmse_item_t                   s_item_i,
  output logic                                   m_valid_o,
  input  logic                                   m_ready_i,
  output tmse_pkg::tmse_result_t                 m_result_o,
  output tmse_pkg::tmse_mem_ctl_t                mem_ctl_o,
  output logic [tmse_pkg::TAPE_AW-1:0]           tape_raddr_o,
  output logic [tmse_pkg::TAPE_AW-1:0]           tape_waddr_o,
  output logic [tmse_pkg::SYMBOL_BITS-1:0]       tape_wdata_o,
  input  logic [tmse_pkg::SYMBOL_BITS-1:0]       tape_rdata_i,
  output logic [$clog2(MAX_STATES)+tmse_pkg::SYMBOL_BITS-1:0] tbl_raddr_o,
  output logic [$clog2(MAX_STATES)+tmse_pkg::SYMBOL_BITS-1:0] tbl_waddr_o,
  output tmse_pkg::tmse_entry_t                  tbl_wdata_o,
  input  tmse_pkg::tmse_entry_t                  tbl_rdata_i,
  output logic [tmse_pkg::SYMBOL_BITS-1:0]       alw_raddr_o,
  output logic [tmse_pkg::SYMBOL_BITS-1:0]       alw_waddr_o,
  output logic                                   alw_wdata_o,
  input  logic                                   alw_rdata_i
);
  import tmse_pkg::*;

  localparam int unsigned SW        = $clog2(MAX_STATES);
  localparam int unsigned TBL_DEPTH = MAX_STATES * SYM_COUNT;
  localparam int unsigned CLR_DEPTH = (TBL_DEPTH > TAPE_CELLS) ? TBL_DEPTH : TAPE_CELLS;
  localparam int unsigned CW        = $clog2(CLR_DEPTH);

  tmse_fsm_e                  fsm_q, fsm_d;
  logic [CW-1:0]              cnt_q, cnt_d;
  logic [SW-1:0]              mstate_q, mstate_d;
  logic signed [TAPE_AW-1:0]  head_q, head_d;
  logic                       out_valid_q, out_valid_d;
  tmse_result_t               out_q, out_d;
  tmse_item_t                 item_q;
  tmse_kind_e                 kind_q;
  logic                       accept;

  logic [8:0]                 limit;
  tmse_entry_t                ent;
  logic                       bad_sym;
  logic                       next_ge;
  tmse_status_e               ex_status;
  logic [SYMBOL_BITS-1:0]     ex_sym;
  logic signed [8:0]          ex_next;
  logic [1:0]                 ex_move;
  logic [SW-1:0]              ex_mstate;
  logic signed [TAPE_AW-1:0]  ex_head;
  logic                       ex_tape_we;
  logic                       ex_tbl_we;
  logic                       ex_alw_we;
  logic [TAPE_AW-1:0]         ex_tape_addr;
  logic [SYMBOL_BITS-1:0]     ex_tape_data;

  // A register value above the table size acts as the table size.
  assign limit = (9'(num_states_i) < 9'(MAX_STATES)) ? 9'(num_states_i) : 9'(MAX_STATES);
  assign ent   = tbl_rdata_i;

  // Outcome of the request held in item_q, evaluated in the execute state.
  always_comb begin
    bad_sym      = (ent.sym != '0) && !alw_rdata_i && (ent.sym != BLANK);
    next_ge      = !ent.next[8] && ({1'b0, ent.next[7:0]} >= limit);
    ex_status    = STATUS_DONE;
    ex_sym       = '0;
    ex_next      = NO_NEXT;
    ex_move      = MOVE_NONE;
    ex_mstate    = mstate_q;
    ex_head      = head_q;
    ex_tape_we   = 1'b0;
    ex_tbl_we    = 1'b0;
    ex_alw_we    = 1'b0;
    ex_tape_addr = tape_addr(head_q);
    ex_tape_data = ent.sym;
    case (kind_q)
      KIND_STEP: begin
        if (9'(mstate_q) >= limit) begin
          ex_status = STATUS_RANGE;
        end else if (!ent.valid) begin
          ex_status = STATUS_NO_TRANS;
        end else begin
          ex_sym  = ent.sym;
          ex_next = ent.next;
          ex_move = ent.move;
          if (next_ge || bad_sym) begin
            ex_status = STATUS_REJECT;
          end else begin
            ex_status = STATUS_APPLIED;
            if (!ent.next[8]) begin
              ex_mstate = SW'(ent.next[7:0]);
            end
            ex_tape_we = (ent.sym != '0) && (ent.sym != BANG);
            // The state and the cell are updated even when the move is refused.
            if (ent.move == MOVE_RIGHT) begin
              if (head_q != HEAD_MAX) begin
                ex_head = head_q + TAPE_AW'(1);
              end else begin
                ex_status = STATUS_LIMIT;
              end
            end else if (ent.move != MOVE_NONE) begin
              if (head_q != HEAD_MIN) begin
                ex_head = head_q - TAPE_AW'(1);
              end else begin
                ex_status = STATUS_LIMIT;
              end
            end
          end
        end
      end
      KIND_LOAD: begin
        ex_tbl_we = 9'(item_q.sidx) < 9'(MAX_STATES);
      end
      KIND_ALLOW: begin
        ex_alw_we = 1'b1;
      end
      KIND_CELL: begin
        ex_tape_we   = 1'b1;
        ex_tape_addr = tape_addr(item_q.cell_pos);
        ex_tape_data = item_q.rsym;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    fsm_d        = fsm_q;
    cnt_d        = cnt_q;
    mstate_d     = mstate_q;
    head_d       = head_q;
    out_valid_d  = out_valid_q && !m_ready_i;
    out_d        = out_q;
    s_ready_o    = 1'b0;
    mem_ctl_o    = '0;
    tape_raddr_o = tape_addr(head_q);
    tape_waddr_o = ex_tape_addr;
    tape_wdata_o = ex_tape_data;
    tbl_raddr_o  = {mstate_q, tape_rdata_i};
    tbl_waddr_o  = {SW'(item_q.sidx), item_q.rsym};
    tbl_wdata_o  = '{valid: item_q.valid, sym: item_q.wsym,
                     next: item_q.goto_state, move: item_q.move};
    alw_raddr_o  = ent.sym;
    alw_waddr_o  = item_q.rsym;
    alw_wdata_o  = item_q.valid;
    case (fsm_q)
      ST_INIT: begin
        if ({1'b0, cnt_q} < (CW + 1)'(TBL_DEPTH)) begin
          mem_ctl_o.tbl_we = 1'b1;
        end
        if ({1'b0, cnt_q} < (CW + 1)'(TAPE_CELLS)) begin
          mem_ctl_o.tape_we = 1'b1;
        end
        if ({1'b0, cnt_q} < (CW + 1)'(SYM_COUNT)) begin
          mem_ctl_o.alw_we = 1'b1;
        end
        tbl_waddr_o  = cnt_q[$clog2(TBL_DEPTH)-1:0];
        tbl_wdata_o  = '0;
        tape_waddr_o = cnt_q[TAPE_AW-1:0];
        tape_wdata_o = BLANK;
        alw_waddr_o  = cnt_q[SYMBOL_BITS-1:0];
        alw_wdata_o  = 1'b0;
        if (cnt_q == CW'(CLR_DEPTH - 1)) begin
          cnt_d = '0;
          fsm_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          case (s_kind_i)
            KIND_STEP: begin
              mem_ctl_o.tape_re = 1'b1;
              fsm_d             = ST_TBL;
            end
            KIND_CLEAR: begin
              fsm_d = ST_CLR;
            end
            default: begin
              fsm_d = ST_EXEC;
            end
          endcase
        end
      end
      ST_TBL: begin
        mem_ctl_o.tbl_re = 1'b1;
        fsm_d            = ST_ALW;
      end
      ST_ALW: begin
        mem_ctl_o.alw_re = 1'b1;
        fsm_d            = ST_EXEC;
      end
      ST_CLR: begin
        mem_ctl_o.tape_we = 1'b1;
        tape_waddr_o      = cnt_q[TAPE_AW-1:0];
        tape_wdata_o      = BLANK;
        if (cnt_q == CW'(TAPE_CELLS - 1)) begin
          cnt_d    = '0;
          mstate_d = '0;
          head_d   = '0;
          fsm_d    = ST_EXEC;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      ST_EXEC: begin
        // Commit only when the result register is free or being drained.
        if (!out_valid_q || m_ready_i) begin
          mem_ctl_o.tape_we = ex_tape_we;
          mem_ctl_o.tbl_we  = ex_tbl_we;
          mem_ctl_o.alw_we  = ex_alw_we;
          mstate_d          = ex_mstate;
          head_d            = ex_head;
          out_valid_d       = 1'b1;
          out_d.status      = ex_status;
          out_d.state       = 6'(ex_mstate);
          out_d.head        = ex_head;
          out_d.sym         = ex_sym;
          out_d.next        = ex_next;
          out_d.move        = ex_move;
          fsm_d             = ST_IDLE;
        end
      end
      default: begin
        fsm_d = ST_IDLE;
      end
    endcase
  end

  assign accept = s_valid_i && s_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q       <= ST_INIT;
      cnt_q       <= '0;
      mstate_q    <= '0;
      head_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      fsm_q       <= fsm_d;
      cnt_q       <= cnt_d;
      mstate_q    <= mstate_d;
      head_q      <= head_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= s_item_i;
      kind_q <= tmse_kind_e'(s_kind_i);
    end
    out_q <= out_d;
  end

  assign m_valid_o  = out_valid_q;
  assign m_result_o = out_q;

  // A new result only appears right after the execute state.
  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fsm_q == ST_EXEC))
    else $error("result raised outside the execute state");

  // The head only moves on a committed request or at the end of a tape clear.
  a_head_changes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(head_q) |-> ($past(fsm_q == ST_EXEC) || $past(fsm_q == ST_CLR)))
    else $error("head changed outside commit or clear");

  // The machine state never leaves the table.
  a_state_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    9'(mstate_q) < 9'(MAX_STATES))
    else $error("machine state beyond table size");

  // The allowed-symbol lookup always follows the table lookup.
  a_read_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fsm_q == ST_ALW) |-> $past(fsm_q == ST_TBL))
    else $error("allowed-symbol read without table read");

endmodule

// File: rtl/turing_machine_step_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Turing machine step engine
// Single-tape machine with a transition table, an allowed-symbol set and a
// 4096-cell tape, driven by a request stream and configured over APB.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on the s_axis channel; tuser carries the request kind
//   (step, load table entry, set symbol allowed, clear and restart, write
//   tape cell) and tdata the operands. Every request yields exactly one
//   result on the m_axis channel with a status, the machine state and head
//   after the request, and the looked-up action of a step.
//   The num_states register (byte address 0) is written over APB; the user
//   must write it only while no request is in flight, as the block itself
//   does not enforce this; pready is always high. A step runs three
//   dependent memory reads in turn: the tape cell under the head, the table
//   entry it selects, then the allowed bit of that entry's symbol; its
//   result is then committed, and only after that commit is the next request
//   accepted. Load, allow and cell writes go straight to the commit. A clear
//   request sweeps the tape one cell per cycle before its commit.
//   After reset the engine clears the table, allowed set and tape in one
//   sweep with s_axis_tready low; APB writes are taken throughout.
//   Results sit in an output register; if the receiver stalls, the engine
//   still accepts one more request and holds its commit until the register
//   drains, so nothing is dropped.
// ----------------------------------------------------------------------------
module turing_machine_step_engine #(
  parameter int unsigned MAX_STATES = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Request stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // From bit 0: state_index[6], read_symbol[8], entry_valid[1], write_symbol[8],
  // goto_state[9], head_move[2], cell_position[12], zero padding[2].
  input  logic [tmse_pkg::TDATA_IN_W-1:0]     s_axis_tdata,
  // From bit 0: kind[3].
  input  logic [2:0]                          s_axis_tuser,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // From bit 0: status[3], state_now[6], head_now[12], action_symbol[8],
  // action_next[9], action_move[2].
  output logic [tmse_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
  // Configuration port.
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [2:0]                          paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import tmse_pkg::*;

  localparam int unsigned SW     = $clog2(MAX_STATES);
  localparam int unsigned TBL_AW = SW + SYMBOL_BITS;

  // Register index taken from the word address.
  localparam logic REG_NUM_STATES = 1'b0;

  logic [6:0]             num_states_q;
  logic                   cfg_write;

  tmse_item_t             item;
  tmse_result_t           result;
  tmse_mem_ctl_t          mem_ctl;
  logic [TAPE_AW-1:0]     tape_raddr;
  logic [TAPE_AW-1:0]     tape_waddr;
  logic [SYMBOL_BITS-1:0] tape_wdata;
  logic [SYMBOL_BITS-1:0] tape_rdata;
  logic [TBL_AW-1:0]      tbl_raddr;
  logic [TBL_AW-1:0]      tbl_waddr;
  tmse_entry_t            tbl_wdata;
  tmse_entry_t            tbl_rdata;
  logic [SYMBOL_BITS-1:0] alw_raddr;
  logic [SYMBOL_BITS-1:0] alw_waddr;
  logic                   alw_wdata;
  logic                   alw_rdata;

  // APB register file: a single register, no wait states.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_NUM_STATES);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_states_q <= '0;
    end else if (cfg_write) begin
      num_states_q <= pwdata[6:0];
    end
  end

  assign prdata = (paddr[2] == REG_NUM_STATES) ? 32'(num_states_q) : '0;

  // The two padding bits at the top of tdata carry nothing.
  assign item         = s_axis_tdata[ITEM_W-1:0];
  assign m_axis_tdata = result;

  tmse_ctrl #(
    .MAX_STATES (MAX_STATES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .num_states_i (num_states_q),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_kind_i     (s_axis_tuser),
    .s_item_i     (item),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_result_o   (result),
    .mem_ctl_o    (mem_ctl),
    .tape_raddr_o (tape_raddr),
    .tape_waddr_o (tape_waddr),
    .tape_wdata_o (tape_wdata),
    .tape_rdata_i (tape_rdata),
    .tbl_raddr_o  (tbl_raddr),
    .tbl_waddr_o  (tbl_waddr),
    .tbl_wdata_o  (tbl_wdata),
    .tbl_rdata_i  (tbl_rdata),
    .alw_raddr_o  (alw_raddr),
    .alw_waddr_o  (alw_waddr),
    .alw_wdata_o  (alw_wdata),
    .alw_rdata_i  (alw_rdata)
  );

  tmse_mem #(
    .MAX_STATES (MAX_STATES)
  ) u_mem (
    .clk_i        (clk_i),
    .mem_ctl_i    (mem_ctl),
    .tape_raddr_i (tape_raddr),
    .tape_waddr_i (tape_waddr),
    .tape_wdata_i (tape_wdata),
    .tape_rdata_o (tape_rdata),
    .tbl_raddr_i  (tbl_raddr),
    .tbl_waddr_i  (tbl_waddr),
    .tbl_wdata_i  (tbl_wdata),
    .tbl_rdata_o  (tbl_rdata),
    .alw_raddr_i  (alw_raddr),
    .alw_waddr_i  (alw_waddr),
    .alw_wdata_i  (alw_wdata),
    .alw_rdata_o  (alw_rdata)
  );

endmodule
